/* hdl/clipped_alpha_blend_blitter_assert.svh */
// Assertion macros for the clipped alpha-blend blitter checker.
// Needs a clk and an active-high rst in the scope where the macros are used.
`ifndef CLIPPED_ALPHA_BLEND_BLITTER_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_BLITTER_ASSERT_SVH

// same-cycle implication, off during reset
`define CABB_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CABB_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// state in the cycle after reset
`define CABB_AST_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* hdl/cabb_pkg.sv */
// Shared types and constants for the clipped alpha-blend blitter.
// No dependencies; imported by every module of the block except cabb_ram.
`default_nettype none

package cabb_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int ATLAS_SIDE    = 128;

  localparam int ATLAS_DEPTH = 16384;
  localparam int ATLAS_AW    = $clog2(ATLAS_DEPTH);
  localparam int ADDR_FULL_W = 18;

  localparam int REM_W  = 20;
  localparam int DIV_W  = 8;
  localparam int IDX_W  = 3;

  // pipeline stage positions
  localparam int ST_CLIP  = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_DIV0  = 3;
  localparam int ST_ADDR  = ST_DIV0 + DIV_W - 1;
  localparam int ST_MEM   = ST_ADDR + 1;
  localparam int ST_ALPHA = ST_MEM + 1;
  localparam int NST      = ST_ALPHA + 1;

  localparam logic [7:0] FILL_MARK = 8'd125;
  localparam logic [7:0] OPAQUE    = 8'hff;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_DEST_W      = 3'd2,
    REG_DEST_H      = 3'd3,
    REG_SRC_RECT    = 3'd4,
    REG_BLEND_COLOR = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        op;
    logic [13:0] texel_index;
    logic [7:0]  texel_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  dest_red;
    logic [7:0]  dest_green;
    logic [7:0]  dest_blue;
  } req_t;

  typedef struct packed {
    logic       inside_res;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
  } rsp_t;

  typedef struct packed {
    logic signed [12:0] dest_x;
    logic signed [12:0] dest_y;
    logic [11:0]        dest_w;
    logic [11:0]        dest_h;
    logic [31:0]        src_rect;
    logic [31:0]        blend_color;
  } cfg_t;

  typedef struct packed {
    logic        in_win;
    logic [11:0] ox;
    logic [11:0] oy;
  } clip_t;

  typedef struct packed {
    req_t             req;
    logic             in_win;
    logic [11:0]      ox;
    logic [11:0]      oy;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [DIV_W-1:0] qx;
    logic [DIV_W-1:0] qy;
    logic [15:0]      alpha;
  } pl_t;

endpackage

`default_nettype wire

/* hdl/cabb_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module cabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // a write leaves the read register alone
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/cabb_clip.sv */
// Clip window test and destination offsets for one pixel.
// Depends on cabb_pkg.
`default_nettype none

module cabb_clip (
  input  cabb_pkg::cfg_t  cfg,
  input  logic [11:0]     x,
  input  logic [11:0]     y,
  output cabb_pkg::clip_t clip
);
  import cabb_pkg::*;

  localparam logic [12:0] LIM_X = 13'(SCREEN_WIDTH);
  localparam logic [12:0] LIM_Y = 13'(SCREEN_HEIGHT);

  function automatic logic [11:0] clamp_edge(input logic signed [13:0] v,
                                             input logic [12:0] lim);
    logic [12:0] top;
    top = lim - 13'd1;
    if (v < 14'sd0) begin
      clamp_edge = 12'd0;
    end else if (v >= $signed({1'b0, lim})) begin
      clamp_edge = top[11:0];
    end else begin
      clamp_edge = v[11:0];
    end
  endfunction

  logic signed [13:0] x0, y0, x1, y1;
  logic [11:0]        sx, sy, ex, ey;
  logic [13:0]        dx, dy;

  always_comb begin
    x0 = {cfg.dest_x[12], cfg.dest_x};
    y0 = {cfg.dest_y[12], cfg.dest_y};
    x1 = x0 + $signed({2'b00, cfg.dest_w});
    y1 = y0 + $signed({2'b00, cfg.dest_h});
    sx = clamp_edge(x0, LIM_X);
    sy = clamp_edge(y0, LIM_Y);
    ex = clamp_edge(x1, LIM_X);
    ey = clamp_edge(y1, LIM_Y);
    dx = {2'b00, x} - x0;
    dy = {2'b00, y} - y0;
    clip.in_win = (x >= sx) && (x < ex) && (y >= sy) && (y < ey) &&
                  (cfg.dest_w != 12'd0) && (cfg.dest_h != 12'd0);
    clip.ox = dx[11:0];
    clip.oy = dy[11:0];
  end

endmodule

`default_nettype wire

/* hdl/cabb_div_step.sv */
// One restoring-division step: trial subtract of the shifted divisor.
// Depends on cabb_pkg.
`default_nettype none

module cabb_div_step (
  input  logic [cabb_pkg::REM_W-1:0] rem_in,
  input  logic [11:0]                dvs,
  input  logic [2:0]                 bit_pos,
  output logic [cabb_pkg::REM_W-1:0] rem_out,
  output logic                       qbit
);
  import cabb_pkg::*;

  logic [REM_W:0] trial;

  always_comb begin
    trial   = {1'b0, rem_in} - ((REM_W + 1)'(dvs) << bit_pos);
    qbit    = !trial[REM_W];
    rem_out = qbit ? trial[REM_W-1:0] : rem_in;
  end

endmodule

`default_nettype wire

/* hdl/cabb_blend.sv */
// Final color blend: pass-through outside the window, else fill, opaque fill or texture-weighted mix per channel.
// Depends on cabb_pkg.
`default_nettype none

module cabb_blend (
  input  cabb_pkg::pl_t  stg,
  input  cabb_pkg::cfg_t cfg,
  output cabb_pkg::rsp_t rsp
);
  import cabb_pkg::*;

  // c + floor(a*(col-c) / 2^k), k = 16 or 8
  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] col,
                                     input logic [15:0] a, input logic sh16);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    logic signed [25:0] s;
    d = $signed({1'b0, col}) - $signed({1'b0, c});
    p = $signed({1'b0, a}) * d;
    s = sh16 ? (p >>> 16) : (p >>> 8);
    mix = s[7:0] + c;
  endfunction

  logic       fill;
  logic [7:0] ca, cr, cg, cb;

  always_comb begin
    fill = cfg.src_rect[7:0] == FILL_MARK;
    cr   = cfg.blend_color[7:0];
    cg   = cfg.blend_color[15:8];
    cb   = cfg.blend_color[23:16];
    ca   = cfg.blend_color[31:24];
    rsp.inside_res = stg.in_win;
    if (!stg.in_win) begin
      rsp.new_red   = stg.req.dest_red;
      rsp.new_green = stg.req.dest_green;
      rsp.new_blue  = stg.req.dest_blue;
    end else if (fill && ca == OPAQUE) begin
      rsp.new_red   = cr;
      rsp.new_green = cg;
      rsp.new_blue  = cb;
    end else begin
      rsp.new_red   = mix(stg.req.dest_red,   cr, stg.alpha, !fill);
      rsp.new_green = mix(stg.req.dest_green, cg, stg.alpha, !fill);
      rsp.new_blue  = mix(stg.req.dest_blue,  cb, stg.alpha, !fill);
    end
  end

endmodule

`default_nettype wire

/* hdl/clipped_alpha_blend_blitter.sv */
// Clipped alpha-blend blitter top level: config registers, pixel pipeline, atlas RAM.
// Depends on cabb_pkg, cabb_clip, cabb_div_step, cabb_ram, cabb_blend.
//
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write registers only while the pipeline is empty.
//   req channel: req_valid/req_stall with one req word. op load writes one atlas
//   texel and gives no response; op blend gives exactly one rsp word.
//   rsp channel: rsp_valid/rsp_stall with one rsp word, in request order.
// Throughput: one word per cycle unless req_stall is high. The texture position
//   division runs as eight pipelined stages, one quotient bit each; the atlas RAM
//   is read or written once per cycle at a single stage, so a load is seen by
//   every later blend.
// Stall: a stalled rsp holds its word; the pipeline keeps closing bubbles behind
//   it and raises req_stall only when every stage is occupied.
// Reset: clears the pipeline, rsp_valid and all config registers.
//   The atlas RAM is not cleared; a texel read before it is loaded is undefined.
`default_nettype none

module clipped_alpha_blend_blitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  cabb_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output cabb_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cabb_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import cabb_pkg::*;

  cfg_t             cfg;
  pl_t              stg [NST];
  pl_t              nxt [NST];
  logic [NST-1:0]   vld;
  logic [NST-1:0]   mv;
  logic             accept;
  clip_t            clip;
  rsp_t             rsp_next;
  logic [REM_W-1:0] rx_out [DIV_W];
  logic [REM_W-1:0] ry_out [DIV_W];
  logic [DIV_W-1:0] qbx, qby;
  logic [8:0]       tx, ty;
  logic [ADDR_FULL_W-1:0] idx_full;
  logic [ATLAS_AW-1:0]    ram_addr;
  logic                   ram_we;
  logic [7:0]             texel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_X:      cfg.dest_x      <= cfg_data[12:0];
        REG_DEST_Y:      cfg.dest_y      <= cfg_data[12:0];
        REG_DEST_W:      cfg.dest_w      <= cfg_data[11:0];
        REG_DEST_H:      cfg.dest_h      <= cfg_data[11:0];
        REG_SRC_RECT:    cfg.src_rect    <= cfg_data;
        REG_BLEND_COLOR: cfg.blend_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage moves when the next stage is empty or moving too
  always_comb begin
    mv[NST-1] = vld[NST-1] && (!rsp_valid || !rsp_stall);
    for (int i = NST - 2; i >= 0; i--) begin
      mv[i] = vld[i] && (!vld[i+1] || mv[i+1]);
    end
    accept    = req_valid && (!vld[0] || mv[0]);
    req_stall = vld[0] && !mv[0];
  end

  cabb_clip u_clip (
    .cfg  (cfg),
    .x    (stg[0].req.pixel_x),
    .y    (stg[0].req.pixel_y),
    .clip (clip)
  );

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    cabb_div_step u_dx (
      .rem_in  (stg[ST_MUL+k].rem_x),
      .dvs     (cfg.dest_w),
      .bit_pos (3'(DIV_W - 1 - k)),
      .rem_out (rx_out[k]),
      .qbit    (qbx[k])
    );
    cabb_div_step u_dy (
      .rem_in  (stg[ST_MUL+k].rem_y),
      .dvs     (cfg.dest_h),
      .bit_pos (3'(DIV_W - 1 - k)),
      .rem_out (ry_out[k]),
      .qbit    (qby[k])
    );
  end

  // atlas address from the finished quotients; loads write at the same stage
  always_comb begin
    tx       = {1'b0, cfg.src_rect[7:0]} + {1'b0, stg[ST_ADDR].qx};
    ty       = {1'b0, cfg.src_rect[15:8]} + {1'b0, stg[ST_ADDR].qy};
    idx_full = ADDR_FULL_W'(ty) * ADDR_FULL_W'(ATLAS_SIDE) + ADDR_FULL_W'(tx);
    ram_we   = stg[ST_ADDR].req.op == OP_LOAD;
    ram_addr = ram_we ? stg[ST_ADDR].req.texel_index : idx_full[ATLAS_AW-1:0];
  end

  cabb_ram #(
    .WIDTH (8),
    .DEPTH (ATLAS_DEPTH)
  ) u_atlas (
    .clk   (clk),
    .en    (mv[ST_ADDR]),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (stg[ST_ADDR].req.texel_value),
    .rdata (texel)
  );

  always_comb begin
    nxt[0]     = stg[0];
    nxt[0].req = req;

    nxt[ST_CLIP]        = stg[ST_CLIP-1];
    nxt[ST_CLIP].in_win = clip.in_win;
    nxt[ST_CLIP].ox     = clip.ox;
    nxt[ST_CLIP].oy     = clip.oy;

    nxt[ST_MUL]       = stg[ST_MUL-1];
    nxt[ST_MUL].rem_x = {8'd0, stg[ST_MUL-1].ox} * {12'd0, cfg.src_rect[23:16]};
    nxt[ST_MUL].rem_y = {8'd0, stg[ST_MUL-1].oy} * {12'd0, cfg.src_rect[31:24]};
    nxt[ST_MUL].qx    = '0;
    nxt[ST_MUL].qy    = '0;

    for (int k = 0; k < DIV_W; k++) begin
      nxt[ST_DIV0+k]       = stg[ST_DIV0+k-1];
      nxt[ST_DIV0+k].rem_x = rx_out[k];
      nxt[ST_DIV0+k].rem_y = ry_out[k];
      nxt[ST_DIV0+k].qx[DIV_W-1-k] = qbx[k];
      nxt[ST_DIV0+k].qy[DIV_W-1-k] = qby[k];
    end

    nxt[ST_MEM] = stg[ST_MEM-1];

    nxt[ST_ALPHA] = stg[ST_ALPHA-1];
    if (cfg.src_rect[7:0] == FILL_MARK) begin
      nxt[ST_ALPHA].alpha = {8'd0, cfg.blend_color[31:24]};
    end else begin
      nxt[ST_ALPHA].alpha = {8'd0, cfg.blend_color[31:24]} * {8'd0, texel};
    end
  end

  cabb_blend u_blend (
    .stg (stg[NST-1]),
    .cfg (cfg),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      vld[0] <= accept || (vld[0] && !mv[0]);
      for (int i = 1; i < NST; i++) begin
        if (i == ST_MEM) begin
          // loads end at the RAM stage
          vld[i] <= (vld[i] && !mv[i]) ||
                    (mv[i-1] && stg[i-1].req.op == OP_BLEND);
        end else begin
          vld[i] <= (vld[i] && !mv[i]) || mv[i-1];
        end
      end
      rsp_valid <= mv[NST-1] || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg[0] <= nxt[0];
    end
    for (int i = 1; i < NST; i++) begin
      if (mv[i-1]) begin
        stg[i] <= nxt[i];
      end
    end
    if (mv[NST-1]) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/cabb_check.sv */
// Port-level checker for the clipped alpha-blend blitter, bound to the top level.
// Depends on cabb_pkg and clipped_alpha_blend_blitter_assert.svh.
`default_nettype none
`include "clipped_alpha_blend_blitter_assert.svh"

module cabb_check (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cabb_pkg::rsp_t rsp,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  // requests back up only behind a blocked response
  `CABB_AST_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "req_stall without blocked rsp")

  `CABB_AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp word dropped")

  `CABB_AST_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

  `CABB_AST_RST(a_reset_empty, !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind clipped_alpha_blend_blitter cabb_check u_cabb_check (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
